// ===== rtl/hasp_pkg.sv =====
`timescale 1ns / 1ps
package hasp_pkg;

    localparam int MAX_N   = 32;
    localparam int COST_W  = 16;
    localparam int IDX_W   = $clog2(MAX_N);
    localparam int ADDR_W  = 2 * IDX_W;
    localparam int CNT_W   = $clog2(MAX_N + 3);
    localparam int SIZE_W  = 6;
    localparam int DUAL_W  = 20;
    localparam int SLK_W   = 22;
    localparam int SUM_W   = 21;
    localparam int RAM_DEPTH = MAX_N * MAX_N;

    // row visit codes
    localparam logic [1:0] VIS_IDLE = 2'd0;
    localparam logic [1:0] VIS_LIVE = 2'd1;
    localparam logic [1:0] VIS_DONE = 2'd2;

    typedef struct packed {
        logic [IDX_W-1:0]        row_index;
        logic [IDX_W-1:0]        assigned_column;
        logic signed [SUM_W-1:0] total_cost;
        logic                    last_row;
    } t_result;

endpackage

// ===== rtl/hasp_cost_ram.sv =====
`timescale 1ns / 1ps
module hasp_cost_ram
    import hasp_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [ADDR_W-1:0]        i_waddr,
    input  logic signed [COST_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0]        i_raddr,
    output logic signed [COST_W-1:0] o_rdata
);

    logic signed [COST_W-1:0] r_mem [RAM_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== rtl/hasp_slack_alu.sv =====
`timescale 1ns / 1ps
module hasp_slack_alu
    import hasp_pkg::*;
(
    input  logic signed [COST_W-1:0] i_cost,
    input  logic signed [DUAL_W-1:0] i_a,
    input  logic signed [DUAL_W-1:0] i_b,
    input  logic signed [SLK_W-1:0]  i_ref,
    input  logic                     i_ref_inf,
    output logic signed [SLK_W-1:0]  o_slack,
    output logic                     o_lt
);

    // 2*cost - a - b, compared against a running reference
    assign o_slack = (SLK_W'(i_cost) <<< 1) - SLK_W'(i_a) - SLK_W'(i_b);
    assign o_lt    = i_ref_inf || (o_slack < i_ref);

endmodule

// ===== rtl/hasp_core.sv =====
`timescale 1ns / 1ps
module hasp_core
    import hasp_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [CNT_W-1:0]         i_n,
    output logic [ADDR_W-1:0]        o_raddr,
    input  logic signed [COST_W-1:0] i_rdata,
    output logic                     o_busy,
    output logic                     o_res_valid,
    input  logic                     i_res_ready,
    output t_result                  o_res
);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_INIT    = 5'd1;
    localparam logic [4:0] S_RMIN_RD = 5'd2;
    localparam logic [4:0] S_RMIN_EX = 5'd3;
    localparam logic [4:0] S_CMIN_RD = 5'd4;
    localparam logic [4:0] S_CMIN_EX = 5'd5;
    localparam logic [4:0] S_GRD_RD  = 5'd6;
    localparam logic [4:0] S_GRD_EX  = 5'd7;
    localparam logic [4:0] S_RND     = 5'd8;
    localparam logic [4:0] S_PUSH    = 5'd9;
    localparam logic [4:0] S_POP     = 5'd10;
    localparam logic [4:0] S_TREE_RD = 5'd11;
    localparam logic [4:0] S_TREE_EX = 5'd12;
    localparam logic [4:0] S_WALK    = 5'd13;
    localparam logic [4:0] S_DMIN    = 5'd14;
    localparam logic [4:0] S_DCHK    = 5'd15;
    localparam logic [4:0] S_DROW    = 5'd16;
    localparam logic [4:0] S_DCOL    = 5'd17;
    localparam logic [4:0] S_SUM_RD  = 5'd18;
    localparam logic [4:0] S_SUM_EX  = 5'd19;
    localparam logic [4:0] S_OUT     = 5'd20;

    logic [4:0]              r_state;
    logic [CNT_W-1:0]        r_n, r_ri, r_ci, r_k, r_rounds, r_updates, r_sp;
    logic [IDX_W-1:0]        r_trow, r_cur;
    logic signed [SLK_W-1:0] r_acc, r_delta;
    logic                    r_acc_inf, r_delta_inf;
    logic signed [DUAL_W-1:0] r_theta;
    logic signed [SUM_W-1:0] r_sum;

    logic signed [DUAL_W-1:0] r_rd [MAX_N];
    logic signed [DUAL_W-1:0] r_cd [MAX_N];
    logic signed [SLK_W-1:0]  r_cs [MAX_N];
    logic [IDX_W-1:0]         r_rm [MAX_N];
    logic [IDX_W-1:0]         r_cm [MAX_N];
    logic [IDX_W-1:0]         r_rpar [MAX_N];
    logic [IDX_W-1:0]         r_cpar [MAX_N];
    logic [IDX_W-1:0]         r_stack [MAX_N];
    logic [1:0]               r_rvis [MAX_N];
    logic [MAX_N-1:0] r_cs_inf, r_rm_v, r_cm_v, r_rcov, r_ccov, r_rpar_v, r_cpar_v;

    logic [IDX_W-1:0]        ri5, ci5, ridx, sp_top, wp;
    logic [CNT_W-1:0]        n_m1, sp_m1;
    logic                    last_r, last_c;
    logic signed [DUAL_W-1:0] alu_a, alu_b;
    logic signed [SLK_W-1:0] alu_ref, alu_s;
    logic                    alu_ref_inf, alu_lt;
    logic signed [SLK_W-1:0] n_acc, n_cs, n_cs_dec;
    logic                    n_cs_inf, n_tight, n_skip, n_dlt, all_matched;

    assign ri5    = r_ri[IDX_W-1:0];
    assign ci5    = r_ci[IDX_W-1:0];
    assign ridx   = (r_state == S_TREE_EX) ? r_trow : ri5;
    assign n_m1   = r_n - 1'b1;
    assign sp_m1  = r_sp - 1'b1;
    assign sp_top = sp_m1[IDX_W-1:0];
    assign last_r = (r_ri == n_m1);
    assign last_c = (r_ci == n_m1);
    assign wp     = r_cpar[r_cur];

    assign alu_a       = (r_state == S_RMIN_EX) ? '0 : r_rd[ridx];
    assign alu_b       = (r_state == S_TREE_EX || r_state == S_GRD_EX) ? r_cd[ci5] : '0;
    assign alu_ref     = (r_state == S_TREE_EX) ? r_cs[ci5] : r_acc;
    assign alu_ref_inf = (r_state == S_TREE_EX) ? r_cs_inf[ci5] : r_acc_inf;

    hasp_slack_alu u_alu (
        .i_cost    (i_rdata),
        .i_a       (alu_a),
        .i_b       (alu_b),
        .i_ref     (alu_ref),
        .i_ref_inf (alu_ref_inf),
        .o_slack   (alu_s),
        .o_lt      (alu_lt)
    );

    assign n_acc    = alu_lt ? alu_s : r_acc;
    assign n_cs     = alu_lt ? alu_s : r_cs[ci5];
    assign n_cs_inf = alu_lt ? 1'b0 : r_cs_inf[ci5];
    assign n_tight  = !n_cs_inf && (n_cs == '0);
    assign n_skip   = (r_cm_v[ci5] && r_cm[ci5] == r_trow) || r_ccov[ci5];
    assign n_dlt    = !r_ccov[ci5] && !r_cs_inf[ci5] && (r_delta_inf || r_cs[ci5] < r_delta);
    assign n_cs_dec = r_cs[ci5] - r_delta;

    always_comb begin
        all_matched = 1'b1;
        for (int j = 0; j < MAX_N; j++) begin
            if (CNT_W'(j) < r_n && !r_rm_v[j]) begin
                all_matched = 1'b0;
            end
        end
    end

    always_comb begin
        unique case (r_state)
            S_SUM_RD: o_raddr = {ri5, r_rm[ri5]};
            S_TREE_RD: o_raddr = {r_trow, ci5};
            default:  o_raddr = {ri5, ci5};
        endcase
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_res_valid = (r_state == S_OUT);
    assign o_res.row_index       = ri5;
    assign o_res.assigned_column = r_rm_v[ri5] ? r_rm[ri5] : '0;
    assign o_res.total_cost      = r_sum;
    assign o_res.last_row        = last_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sp    <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_n     <= i_n;
                        r_state <= S_INIT;
                    end
                end
                S_INIT: begin
                    for (int j = 0; j < MAX_N; j++) begin
                        r_rd[j]   <= '0;
                        r_cd[j]   <= '0;
                        r_rvis[j] <= VIS_IDLE;
                    end
                    r_cs_inf  <= '1;
                    r_rm_v    <= '0;
                    r_cm_v    <= '0;
                    r_rcov    <= '0;
                    r_ccov    <= '0;
                    r_rpar_v  <= '0;
                    r_cpar_v  <= '0;
                    r_sp      <= '0;
                    r_ri      <= '0;
                    r_ci      <= '0;
                    r_acc_inf <= 1'b1;
                    r_state   <= S_RMIN_RD;
                end
                S_RMIN_RD: r_state <= S_RMIN_EX;
                S_RMIN_EX: begin
                    r_acc     <= n_acc;
                    r_acc_inf <= 1'b0;
                    r_state   <= S_RMIN_RD;
                    if (last_c) begin
                        r_rd[ri5] <= DUAL_W'(n_acc);
                        r_acc_inf <= 1'b1;
                        r_ci      <= '0;
                        if (last_r) begin
                            r_ri    <= '0;
                            r_state <= S_CMIN_RD;
                        end else begin
                            r_ri <= r_ri + 1'b1;
                        end
                    end else begin
                        r_ci <= r_ci + 1'b1;
                    end
                end
                S_CMIN_RD: r_state <= S_CMIN_EX;
                S_CMIN_EX: begin
                    r_acc     <= n_acc;
                    r_acc_inf <= 1'b0;
                    r_state   <= S_CMIN_RD;
                    if (last_r) begin
                        r_cd[ci5] <= DUAL_W'(n_acc);
                        r_acc_inf <= 1'b1;
                        r_ri      <= '0;
                        if (last_c) begin
                            r_ci    <= '0;
                            r_state <= S_GRD_RD;
                        end else begin
                            r_ci <= r_ci + 1'b1;
                        end
                    end else begin
                        r_ri <= r_ri + 1'b1;
                    end
                end
                S_GRD_RD: r_state <= S_GRD_EX;
                S_GRD_EX: begin
                    r_state <= S_GRD_RD;
                    if ((!r_rm_v[ri5] && alu_s == '0) || last_r) begin
                        if (!r_rm_v[ri5] && alu_s == '0) begin
                            r_rm[ri5]   <= ci5;
                            r_rm_v[ri5] <= 1'b1;
                            r_cm[ci5]   <= ri5;
                            r_cm_v[ci5] <= 1'b1;
                        end
                        r_ri <= '0;
                        if (last_c) begin
                            r_rounds <= '0;
                            r_state  <= S_RND;
                        end else begin
                            r_ci <= r_ci + 1'b1;
                        end
                    end else begin
                        r_ri <= r_ri + 1'b1;
                    end
                end
                S_RND: begin
                    for (int j = 0; j < MAX_N; j++) begin
                        if (CNT_W'(j) < r_n) begin
                            r_rvis[j]   <= r_rm_v[j] ? VIS_IDLE : VIS_LIVE;
                            r_rcov[j]   <= r_rm_v[j];
                            r_ccov[j]   <= 1'b0;
                            r_cs_inf[j] <= 1'b1;
                        end
                    end
                    r_ri <= '0;
                    if (all_matched) begin
                        r_sum   <= '0;
                        r_state <= S_SUM_RD;
                    end else begin
                        r_updates <= '0;
                        r_sp      <= '0;
                        r_state   <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (r_rvis[ri5] == VIS_LIVE && r_sp < CNT_W'(MAX_N)) begin
                        r_stack[r_sp[IDX_W-1:0]] <= ri5;
                        r_sp <= r_sp + 1'b1;
                    end
                    if (last_r) begin
                        r_state <= S_POP;
                    end else begin
                        r_ri <= r_ri + 1'b1;
                    end
                end
                S_POP: begin
                    if (r_sp == '0) begin
                        if (r_updates > r_n + 1'b1) begin
                            r_ri    <= '0;
                            r_sum   <= '0;
                            r_state <= S_SUM_RD;
                        end else begin
                            r_ci        <= '0;
                            r_delta_inf <= 1'b1;
                            r_state     <= S_DMIN;
                        end
                    end else begin
                        r_trow  <= r_stack[sp_top];
                        r_sp    <= sp_m1;
                        r_ci    <= '0;
                        r_state <= S_TREE_RD;
                    end
                end
                S_TREE_RD: begin
                    if (n_skip) begin
                        if (last_c) begin
                            r_rvis[r_trow] <= VIS_DONE;
                            r_state        <= S_POP;
                        end else begin
                            r_ci <= r_ci + 1'b1;
                        end
                    end else begin
                        r_state <= S_TREE_EX;
                    end
                end
                S_TREE_EX: begin
                    if (alu_lt) begin
                        r_cs[ci5]     <= alu_s;
                        r_cs_inf[ci5] <= 1'b0;
                        r_cpar[ci5]   <= r_trow;
                        r_cpar_v[ci5] <= 1'b1;
                    end
                    if (n_tight && !r_cm_v[ci5]) begin
                        // free column reached: augment
                        r_cur   <= ci5;
                        r_k     <= '0;
                        r_state <= S_WALK;
                    end else begin
                        if (n_tight) begin
                            r_rpar[r_cm[ci5]]   <= ci5;
                            r_rpar_v[r_cm[ci5]] <= 1'b1;
                            r_rcov[r_cm[ci5]]   <= 1'b0;
                            r_ccov[ci5]         <= 1'b1;
                            r_rvis[r_cm[ci5]]   <= VIS_LIVE;
                            if (r_sp < CNT_W'(MAX_N)) begin
                                r_stack[r_sp[IDX_W-1:0]] <= r_cm[ci5];
                                r_sp <= r_sp + 1'b1;
                            end
                        end
                        if (last_c) begin
                            r_rvis[r_trow] <= VIS_DONE;
                            r_state        <= S_POP;
                        end else begin
                            r_ci    <= r_ci + 1'b1;
                            r_state <= S_TREE_RD;
                        end
                    end
                end
                S_WALK: begin
                    if (r_k > r_n || !r_cpar_v[r_cur] || !r_rpar_v[wp]) begin
                        if (r_k <= r_n && r_cpar_v[r_cur]) begin
                            r_rm[wp]      <= r_cur;
                            r_rm_v[wp]    <= 1'b1;
                            r_cm[r_cur]   <= wp;
                            r_cm_v[r_cur] <= 1'b1;
                        end
                        if (r_rounds >= r_n) begin
                            r_ri    <= '0;
                            r_sum   <= '0;
                            r_state <= S_SUM_RD;
                        end else begin
                            r_rounds <= r_rounds + 1'b1;
                            r_state  <= S_RND;
                        end
                    end else begin
                        r_rm[wp]      <= r_cur;
                        r_rm_v[wp]    <= 1'b1;
                        r_cm[r_cur]   <= wp;
                        r_cm_v[r_cur] <= 1'b1;
                        r_k           <= r_k + 1'b1;
                        r_cur         <= r_rpar[wp];
                    end
                end
                S_DMIN: begin
                    if (n_dlt) begin
                        r_delta     <= r_cs[ci5];
                        r_delta_inf <= 1'b0;
                    end
                    if (last_c) begin
                        r_state <= S_DCHK;
                    end else begin
                        r_ci <= r_ci + 1'b1;
                    end
                end
                S_DCHK: begin
                    r_ri <= '0;
                    if (r_delta_inf || r_delta <= '0) begin
                        r_sum   <= '0;
                        r_state <= S_SUM_RD;
                    end else begin
                        r_theta <= DUAL_W'(r_delta >>> 1);
                        r_state <= S_DROW;
                    end
                end
                S_DROW: begin
                    r_rd[ri5] <= r_rcov[ri5] ? r_rd[ri5] - r_theta : r_rd[ri5] + r_theta;
                    if (last_r) begin
                        r_ci    <= '0;
                        r_state <= S_DCOL;
                    end else begin
                        r_ri <= r_ri + 1'b1;
                    end
                end
                S_DCOL: begin
                    if (r_ccov[ci5]) begin
                        r_cd[ci5] <= r_cd[ci5] - r_theta;
                    end else begin
                        r_cd[ci5] <= r_cd[ci5] + r_theta;
                        if (!r_cs_inf[ci5]) begin
                            r_cs[ci5] <= n_cs_dec;
                            if (n_cs_dec == '0 && r_cpar_v[ci5]) begin
                                r_rvis[r_cpar[ci5]] <= VIS_LIVE;
                            end
                        end
                    end
                    if (last_c) begin
                        r_updates <= r_updates + 1'b1;
                        r_sp      <= '0;
                        r_ri      <= '0;
                        r_state   <= S_PUSH;
                    end else begin
                        r_ci <= r_ci + 1'b1;
                    end
                end
                S_SUM_RD: r_state <= S_SUM_EX;
                S_SUM_EX: begin
                    if (r_rm_v[ri5]) begin
                        r_sum <= r_sum + {{(SUM_W-COST_W){i_rdata[COST_W-1]}}, i_rdata};
                    end
                    if (last_r) begin
                        r_ri    <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_ri    <= r_ri + 1'b1;
                        r_state <= S_SUM_RD;
                    end
                end
                S_OUT: begin
                    if (i_res_ready) begin
                        if (last_r) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_ri <= r_ri + 1'b1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= CNT_W'(MAX_N))
        else $error("row stack overflow");

    a_out_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT |-> r_ri < r_n)
        else $error("result row beyond matrix side");

    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_start) |=> r_state == S_INIT)
        else $error("solve did not start");

    a_idle_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_busy) |-> $past(r_state) == S_OUT)
        else $error("solve ended without delivering results");

endmodule

// ===== rtl/hungarian_assignment_solver_top.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake                    Payload
// in        input      i_in_valid / o_in_ready      i_cost_value
// out       output     o_out_valid / i_out_ready    o_row_index, o_assigned_column,
//                                                   o_total_cost, o_last_row
// cfg       input      i_cfg_valid / o_cfg_ready    i_cfg_data (matrix_size)
//
// Costs load at one transaction per cycle, row-major, into an on-chip cost RAM.
// After the n*n-th cost the solver runs. Each read of a cost (reductions, greedy
// match, tree growth, final sum) uses the single RAM read port: a read state sends
// the address, an execute state uses the data. Reductions, greedy match and tree
// growth share the slack adder; a column skipped in tree growth has no execute
// state. A tree search visits up to n^2 costs, a round allows up to n+2 dual
// updates and a solve up to n+1 rounds. A dual update finds the least slack,
// updates row then column duals and restacks live rows. Results leave one row per
// cycle while out is ready. in and cfg are not ready while a solve or the result
// drain is in progress; in also waits while cfg is offered, so cfg goes first.
// Synchronous active-low reset; no clearing pass (cost RAM is written before read).
module hungarian_assignment_solver_top
    import hasp_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic signed [COST_W-1:0] i_cost_value,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [IDX_W-1:0]         o_row_index,
    output logic [IDX_W-1:0]         o_assigned_column,
    output logic signed [SUM_W-1:0]  o_total_cost,
    output logic                     o_last_row,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [SIZE_W-1:0]        i_cfg_data
);

    logic [SIZE_W-1:0]        r_size;
    logic [IDX_W-1:0]         r_lrow, r_lcol;
    logic [CNT_W-1:0]         side, side_m1;
    logic                     busy, in_xact, cfg_xact, load_last, start;
    logic [ADDR_W-1:0]        raddr;
    logic signed [COST_W-1:0] rdata;
    t_result                  res;

    // a size of zero acts as one, above MAX_N as MAX_N
    always_comb begin
        if (r_size == '0) begin
            side = CNT_W'(1);
        end else if (CNT_W'(r_size) > CNT_W'(MAX_N)) begin
            side = CNT_W'(MAX_N);
        end else begin
            side = CNT_W'(r_size);
        end
    end
    assign side_m1 = side - 1'b1;

    assign o_in_ready  = !busy && !i_cfg_valid;
    assign o_cfg_ready = !busy;
    assign in_xact     = i_in_valid && o_in_ready;
    assign cfg_xact    = i_cfg_valid && o_cfg_ready;
    assign load_last   = (CNT_W'(r_lrow) == side_m1) && (CNT_W'(r_lcol) == side_m1);
    assign start       = in_xact && load_last;

    // config write restarts the load; load counters track row and column
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_W'(MAX_N);
            r_lrow <= '0;
            r_lcol <= '0;
        end else if (cfg_xact) begin
            r_size <= i_cfg_data;
            r_lrow <= '0;
            r_lcol <= '0;
        end else if (in_xact) begin
            if (load_last) begin
                r_lrow <= '0;
                r_lcol <= '0;
            end else if (CNT_W'(r_lcol) == side_m1) begin
                r_lcol <= '0;
                r_lrow <= r_lrow + 1'b1;
            end else begin
                r_lcol <= r_lcol + 1'b1;
            end
        end
    end

    hasp_cost_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (in_xact),
        .i_waddr ({r_lrow, r_lcol}),
        .i_wdata (i_cost_value),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    hasp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_n         (side),
        .o_raddr     (raddr),
        .i_rdata     (rdata),
        .o_busy      (busy),
        .o_res_valid (o_out_valid),
        .i_res_ready (i_out_ready),
        .o_res       (res)
    );

    assign o_row_index       = res.row_index;
    assign o_assigned_column = res.assigned_column;
    assign o_total_cost      = res.total_cost;
    assign o_last_row        = res.last_row;

endmodule
